/* rtl/core/cia_pkg.sv */
`timescale 1ns / 1ps
package cia_pkg;
    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_FLOORDIV = 4'd4;
    localparam logic [3:0] OP_MOD      = 4'd5;
    localparam logic [3:0] OP_LT       = 4'd6;
    localparam logic [3:0] OP_LE       = 4'd7;
    localparam logic [3:0] OP_GT       = 4'd8;
    localparam logic [3:0] OP_GE       = 4'd9;
    localparam logic [3:0] OP_EQ       = 4'd10;
    localparam logic [3:0] OP_NE       = 4'd11;
    localparam logic [3:0] OP_MIN      = 4'd12;
    localparam logic [3:0] OP_MAX      = 4'd13;
    localparam logic [3:0] OP_CEILDIV  = 4'd14;
    localparam logic [3:0] OP_NEG      = 4'd15;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVF      = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;
    localparam logic [1:0] ST_DOMAIN   = 2'd3;

    localparam int OUT_WIDTH = 64;
endpackage

/* rtl/core/cia_div_pipe.sv */
`timescale 1ns / 1ps
module cia_div_pipe #(
    parameter int W      = 64,
    parameter int SIDE_W = 72
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_dividend,
    input  logic [W-1:0]      i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_quot,
    output logic [W-1:0]      o_rem,
    output logic [SIDE_W-1:0] o_side
);
    logic              r_v    [W];
    logic [W-1:0]      r_rem  [W];
    logic [W-1:0]      r_q    [W];
    logic [W-1:0]      r_d    [W];
    logic [SIDE_W-1:0] r_side [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic              v_in;
        logic [W-1:0]      rem_in, q_in, d_in;
        logic [SIDE_W-1:0] side_in;
        logic [W:0]        sh, trial;
        logic [W-1:0]      n_rem, n_q;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign q_in    = i_dividend;
            assign d_in    = i_divisor;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign d_in    = r_d[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            sh    = {rem_in, q_in[W-1]};
            trial = sh - {1'b0, d_in};
            if (!trial[W]) begin
                n_rem = trial[W-1:0];
                n_q   = {q_in[W-2:0], 1'b1};
            end else begin
                n_rem = sh[W-1:0];
                n_q   = {q_in[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_d[k]    <= d_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quot  = r_q[W-1];
    assign o_rem   = r_rem[W-1];
    assign o_side  = r_side[W-1];
endmodule

/* rtl/core/checked_int64_alu.sv */
`timescale 1ns / 1ps
// Overflow-checked signed integer ALU.
// Input stream (s_axis): one operation per transfer; tdata carries the
// opcode and two signed operands. Only the low DATA_WIDTH bits of each
// operand are used, read as two's complement.
// Output stream (m_axis): one result per operation, in order; tdata carries
// the value (sign-extended to 64 bits, zero on error) and a 2-bit status
// (ok, overflow, division by zero, ceildiv domain error).
// Most of the pipeline depth is in the divider, which retires one
// quotient bit per stage. Multiply uses half-width partial products over
// three stages ahead of the divider. Throughput: one operation per cycle
// while the receiver does not stall the output.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver holds tready low with a result waiting, the whole
// pipeline freezes and s_axis tready drops; nothing is lost or repeated.
module checked_int64_alu
    import cia_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [3:0] req_type, [67:4] operand_a, [131:68] operand_b, [135:132] zero
    input  logic [135:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [63:0] value, [65:64] status, [71:66] zero
    output logic [71:0]  o_m_axis_tdata
);
    localparam int W      = DATA_WIDTH;
    localparam int H      = (W + 1) / 2;
    localparam int HW     = W - H;
    localparam int SIDE_W = W + 8;

    logic en;
    logic r_out_v;
    assign en              = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 0: input register
    logic         r_s0_v;
    logic [3:0]   r_s0_op;
    logic [W-1:0] r_s0_a, r_s0_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_s_axis_tvalid;
        end
        if (en) begin
            r_s0_op <= i_s_axis_tdata[3:0];
            r_s0_a  <= i_s_axis_tdata[4 +: W];
            r_s0_b  <= i_s_axis_tdata[68 +: W];
        end
    end

    // stage 1: magnitudes, status checks and the ops that need no multiply or divide
    logic [W-1:0] minv, sum, dif, ma, mb, n_s1_val;
    logic         a_neg, b_neg, ov_add, ov_sub, lt, gt, eq;
    logic [1:0]   n_s1_st;

    always_comb begin
        minv     = {1'b1, {(W-1){1'b0}}};
        a_neg    = r_s0_a[W-1];
        b_neg    = r_s0_b[W-1];
        sum      = r_s0_a + r_s0_b;
        dif      = r_s0_a - r_s0_b;
        ov_add   = ~(r_s0_a[W-1] ^ r_s0_b[W-1]) & (r_s0_a[W-1] ^ sum[W-1]);
        ov_sub   = (r_s0_a[W-1] ^ r_s0_b[W-1]) & (r_s0_a[W-1] ^ dif[W-1]);
        ma       = a_neg ? (W'(0) - r_s0_a) : r_s0_a;
        mb       = b_neg ? (W'(0) - r_s0_b) : r_s0_b;
        lt       = $signed(r_s0_a) < $signed(r_s0_b);
        gt       = $signed(r_s0_a) > $signed(r_s0_b);
        eq       = r_s0_a == r_s0_b;
        n_s1_st  = ST_OK;
        n_s1_val = '0;
        unique case (r_s0_op)
            OP_ADD: begin
                if (ov_add) n_s1_st = ST_OVF; else n_s1_val = sum;
            end
            OP_SUB: begin
                if (ov_sub) n_s1_st = ST_OVF; else n_s1_val = dif;
            end
            OP_MUL: n_s1_val = '0;
            OP_DIV, OP_FLOORDIV, OP_MOD: begin
                if (r_s0_b == '0) n_s1_st = ST_DIVZERO;
                else if (r_s0_a == minv && r_s0_b == '1) n_s1_st = ST_OVF;
            end
            OP_LT: n_s1_val = W'(lt);
            OP_LE: n_s1_val = W'(!gt);
            OP_GT: n_s1_val = W'(gt);
            OP_GE: n_s1_val = W'(!lt);
            OP_EQ: n_s1_val = W'(eq);
            OP_NE: n_s1_val = W'(!eq);
            OP_MIN: n_s1_val = gt ? r_s0_b : r_s0_a;
            OP_MAX: n_s1_val = lt ? r_s0_b : r_s0_a;
            OP_CEILDIV: begin
                if (a_neg || b_neg || r_s0_b == '0) n_s1_st = ST_DOMAIN;
            end
            OP_NEG: begin
                if (r_s0_a == minv) n_s1_st = ST_OVF; else n_s1_val = W'(0) - r_s0_a;
            end
            default: n_s1_st = ST_OK;
        endcase
    end

    logic         r_s1_v, r_s1_aneg, r_s1_diff;
    logic [3:0]   r_s1_op;
    logic [W-1:0] r_s1_ma, r_s1_mb, r_s1_val;
    logic [1:0]   r_s1_st;

    // stage 2: partial products
    logic         r_s2_v, r_s2_aneg, r_s2_diff;
    logic [3:0]   r_s2_op;
    logic [W-1:0] r_s2_ma, r_s2_mb, r_s2_val;
    logic [1:0]   r_s2_st;
    logic [2*H-1:0]  r_s2_ll;
    logic [W-1:0]    r_s2_lh, r_s2_hl;
    logic [2*HW-1:0] r_s2_hh;

    // stage 3: product
    logic         r_s3_v, r_s3_aneg, r_s3_diff;
    logic [3:0]   r_s3_op;
    logic [W-1:0] r_s3_ma, r_s3_mb, r_s3_val;
    logic [1:0]   r_s3_st;
    logic [2*W-1:0] r_s3_prod;

    // stage 4: multiply check
    logic         r_s4_v, r_s4_aneg, r_s4_diff;
    logic [3:0]   r_s4_op;
    logic [W-1:0] r_s4_ma, r_s4_mb, r_s4_val;
    logic [1:0]   r_s4_st;

    logic         mul_ovf;
    logic [W-1:0] n_s4_val;
    logic [1:0]   n_s4_st;

    always_comb begin
        mul_ovf  = (|r_s3_prod[2*W-1:W])
                   | (r_s3_prod[W-1] & (!r_s3_diff | (|r_s3_prod[W-2:0])));
        n_s4_val = r_s3_val;
        n_s4_st  = r_s3_st;
        if (r_s3_op == OP_MUL) begin
            if (mul_ovf) n_s4_st = ST_OVF;
            else n_s4_val = r_s3_diff ? (W'(0) - r_s3_prod[W-1:0]) : r_s3_prod[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
        if (en) begin
            r_s1_op   <= r_s0_op;
            r_s1_aneg <= a_neg;
            r_s1_diff <= a_neg ^ b_neg;
            r_s1_ma   <= ma;
            r_s1_mb   <= mb;
            r_s1_val  <= n_s1_val;
            r_s1_st   <= n_s1_st;

            r_s2_op   <= r_s1_op;
            r_s2_aneg <= r_s1_aneg;
            r_s2_diff <= r_s1_diff;
            r_s2_ma   <= r_s1_ma;
            r_s2_mb   <= r_s1_mb;
            r_s2_val  <= r_s1_val;
            r_s2_st   <= r_s1_st;
            r_s2_ll   <= r_s1_ma[H-1:0] * r_s1_mb[H-1:0];
            r_s2_lh   <= r_s1_ma[H-1:0] * r_s1_mb[W-1:H];
            r_s2_hl   <= r_s1_ma[W-1:H] * r_s1_mb[H-1:0];
            r_s2_hh   <= r_s1_ma[W-1:H] * r_s1_mb[W-1:H];

            r_s3_op   <= r_s2_op;
            r_s3_aneg <= r_s2_aneg;
            r_s3_diff <= r_s2_diff;
            r_s3_ma   <= r_s2_ma;
            r_s3_mb   <= r_s2_mb;
            r_s3_val  <= r_s2_val;
            r_s3_st   <= r_s2_st;
            r_s3_prod <= (2*W)'(r_s2_ll)
                         + (((2*W)'(r_s2_lh) + (2*W)'(r_s2_hl)) << H)
                         + ((2*W)'(r_s2_hh) << (2*H));

            r_s4_op   <= r_s3_op;
            r_s4_aneg <= r_s3_aneg;
            r_s4_diff <= r_s3_diff;
            r_s4_ma   <= r_s3_ma;
            r_s4_mb   <= r_s3_mb;
            r_s4_val  <= n_s4_val;
            r_s4_st   <= n_s4_st;
        end
    end

    // divider
    logic              d_v;
    logic [W-1:0]      d_q, d_rem;
    logic [SIDE_W-1:0] d_side;

    cia_div_pipe #(
        .W      (W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_s4_v),
        .i_dividend (r_s4_ma),
        .i_divisor  (r_s4_mb),
        .i_side     ({r_s4_op, r_s4_aneg, r_s4_diff, r_s4_st, r_s4_val}),
        .o_valid    (d_v),
        .o_quot     (d_q),
        .o_rem      (d_rem),
        .o_side     (d_side)
    );

    // output stage
    logic [3:0]   f_op;
    logic         f_aneg, f_diff, rem_nz;
    logic [1:0]   f_st;
    logic [W-1:0] f_val, n_res;

    assign {f_op, f_aneg, f_diff, f_st, f_val} = d_side;

    always_comb begin
        rem_nz = |d_rem;
        n_res  = f_val;
        unique case (f_op)
            OP_DIV:      n_res = f_diff ? (W'(0) - d_q) : d_q;
            OP_FLOORDIV: begin
                if (!f_diff) n_res = d_q;
                else if (rem_nz) n_res = ~d_q;
                else n_res = W'(0) - d_q;
            end
            OP_MOD:      n_res = f_aneg ? (W'(0) - d_rem) : d_rem;
            OP_CEILDIV:  n_res = d_q + W'(rem_nz);
            default:     n_res = f_val;
        endcase
        if (f_st != ST_OK) n_res = '0;
    end

    logic [3:0]           r_out_op;
    logic [OUT_WIDTH-1:0] r_out_val;
    logic [1:0]           r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d_v;
        end
        if (en) begin
            r_out_op  <= f_op;
            r_out_st  <= f_st;
            r_out_val <= OUT_WIDTH'($signed(n_res));
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {6'd0, r_out_st, r_out_val};

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_st != ST_OK |-> r_out_val == '0)
        else $error("nonzero value with error status");
    a_cmp_bool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && (r_out_op == OP_LT || r_out_op == OP_LE || r_out_op == OP_GT
                    || r_out_op == OP_GE || r_out_op == OP_EQ || r_out_op == OP_NE)
        |-> r_out_val[OUT_WIDTH-1:1] == '0)
        else $error("comparison result not 0 or 1");
    a_domain_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_st == ST_DOMAIN |-> r_out_op == OP_CEILDIV)
        else $error("domain error on non-ceildiv op");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s4_v) && $stable(r_s0_v))
        else $error("pipeline moved during stall");
`endif
endmodule

/* tb/tb_checked_int64_alu.sv */
`timescale 1ns / 1ps
module tb_checked_int64_alu;
    import cia_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } t_alu_result;

    typedef struct {
        logic [3:0]  op;
        logic [63:0] a;
        logic [63:0] b;
        logic        has_exp;
        logic [63:0] value;
        logic [1:0]  status;
    } t_vec;

    localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] NEG1 = 64'hffff_ffff_ffff_ffff;
    localparam int LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // [3:0] req_type, [67:4] operand_a, [131:68] operand_b, [135:132] zero
    logic [135:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // [63:0] value, [65:64] status, [71:66] zero
    logic [71:0]  o_m_axis_tdata;

    t_alu_result pending_results[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 27;
    int recv_idle_pct = 85;

    checked_int64_alu i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_alu_result alu_predict(logic [3:0] op, logic [63:0] a, logic [63:0] b);
        t_alu_result r;
        logic signed [63:0] sa, sb;
        logic [63:0] s, ma, mb, q, rm, lim;
        logic [127:0] p;
        logic diff;
        sa = a;
        sb = b;
        r.value = '0;
        r.status = ST_OK;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        diff = a[63] ^ b[63];
        case (op)
            OP_ADD, OP_SUB: begin
                s = (op == OP_ADD) ? a + b : a - b;
                if (op == OP_ADD ? (a[63] == b[63] && s[63] != a[63])
                                 : (a[63] != b[63] && s[63] != a[63]))
                    r.status = ST_OVF;
                else r.value = s;
            end
            OP_MUL: begin
                lim = diff ? MINV : MAXV;
                p = ma * mb;
                if (p > {64'd0, lim}) r.status = ST_OVF;
                else r.value = diff ? -p[63:0] : p[63:0];
            end
            OP_DIV, OP_FLOORDIV, OP_MOD: begin
                if (b == 0) r.status = ST_DIVZERO;
                else if (a == MINV && b == NEG1) r.status = ST_OVF;
                else begin
                    q = ma / mb;
                    rm = ma % mb;
                    if (op == OP_MOD) r.value = a[63] ? -rm : rm;
                    else begin
                        r.value = diff ? -q : q;
                        if (op == OP_FLOORDIV && rm != 0 && diff) r.value = r.value - 1;
                    end
                end
            end
            OP_LT: r.value = 64'(sa < sb);
            OP_LE: r.value = 64'(sa <= sb);
            OP_GT: r.value = 64'(sa > sb);
            OP_GE: r.value = 64'(sa >= sb);
            OP_EQ: r.value = 64'(a == b);
            OP_NE: r.value = 64'(a != b);
            OP_MIN: r.value = (sb < sa) ? b : a;
            OP_MAX: r.value = (sa < sb) ? b : a;
            OP_CEILDIV: begin
                if (a[63] || b[63] || b == 0) r.status = ST_DOMAIN;
                else r.value = a / b + ((a % b) != 0 ? 64'd1 : 64'd0);
            end
            default: begin
                if (a == MINV) r.status = ST_OVF;
                else r.value = -a;
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return MINV + 64'($urandom_range(0, 3));
            1: return MAXV - 64'($urandom_range(0, 3));
            2: return 64'($signed($urandom_range(0, 20)) - 10);
            3: return 64'($signed($urandom));
            4: return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_op(logic [3:0] op, logic [63:0] a, logic [63:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {4'd0, b, a, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), alu_predict(op, a, b));
    endtask

    always @(posedge i_clk) begin
        t_alu_result got, exp_r;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.value = o_m_axis_tdata[63:0];
            got.status = o_m_axis_tdata[65:64];
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.value !== exp_r.value) begin
                    $error("value exp %h got %h", exp_r.value, got.value);
                    errors++;
                end
                if (got.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status);
                    errors++;
                end
            end
        end
    end

    t_vec vecs[$];

    task automatic add_vec(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                           logic has_exp = 0, logic [63:0] v = 0, logic [1:0] st = 0);
        t_vec row;
        row = '{op, a, b, has_exp, v, st};
        vecs.insert(vecs.size(), row);
    endtask

    initial begin
        int phase;
        int waited;
        add_vec(OP_ADD, MAXV, 64'd1, 1, 64'd0, ST_OVF);
        add_vec(OP_ADD, MINV, NEG1, 1, 64'd0, ST_OVF);
        add_vec(OP_SUB, MINV, 64'd1, 1, 64'd0, ST_OVF);
        add_vec(OP_SUB, 64'd0, MINV, 1, 64'd0, ST_OVF);
        add_vec(OP_MUL, MINV, 64'd1, 1, MINV, ST_OK);
        add_vec(OP_MUL, MINV, NEG1, 1, 64'd0, ST_OVF);
        add_vec(OP_MUL, MAXV, 64'd2, 1, 64'd0, ST_OVF);
        add_vec(OP_DIV, 64'd7, 64'd0, 1, 64'd0, ST_DIVZERO);
        add_vec(OP_DIV, MINV, NEG1, 1, 64'd0, ST_OVF);
        add_vec(OP_FLOORDIV, MINV, NEG1, 1, 64'd0, ST_OVF);
        add_vec(OP_MOD, MINV, NEG1, 1, 64'd0, ST_OVF);
        add_vec(OP_MOD, 64'd5, 64'd0, 1, 64'd0, ST_DIVZERO);
        add_vec(OP_FLOORDIV, -64'sd7, 64'd2);
        add_vec(OP_MOD, -64'sd7, 64'd2);
        add_vec(OP_LT, MINV, MAXV, 1, 64'd1, ST_OK);
        add_vec(OP_LE, MAXV, MAXV, 1, 64'd1, ST_OK);
        add_vec(OP_GT, MINV, MAXV, 1, 64'd0, ST_OK);
        add_vec(OP_GE, NEG1, 64'd0, 1, 64'd0, ST_OK);
        add_vec(OP_EQ, NEG1, NEG1, 1, 64'd1, ST_OK);
        add_vec(OP_NE, NEG1, NEG1, 1, 64'd0, ST_OK);
        add_vec(OP_MIN, MINV, MAXV, 1, MINV, ST_OK);
        add_vec(OP_MAX, MINV, MAXV, 1, MAXV, ST_OK);
        add_vec(OP_CEILDIV, NEG1, 64'd0, 1, 64'd0, ST_DOMAIN);
        add_vec(OP_CEILDIV, 64'd7, 64'd0, 1, 64'd0, ST_DOMAIN);
        add_vec(OP_CEILDIV, MAXV, 64'd2);
        add_vec(OP_NEG, MINV, 64'd0, 1, 64'd0, ST_OVF);
        add_vec(OP_NEG, MAXV, MAXV, 1, MINV + 1, ST_OK);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vecs[k]) begin
            send_op(vecs[k].op, vecs[k].a, vecs[k].b);
            if (vecs[k].has_exp) begin
                pending_results[$].value = vecs[k].value;
                pending_results[$].status = vecs[k].status;
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 85 : 0;
            recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 27 : 0;
            repeat (430) send_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        waited = 0;
        while (waited < 100) begin
            @(posedge i_clk);
            waited++;
        end
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

/* files.f */
rtl/core/cia_pkg.sv
rtl/core/cia_div_pipe.sv
rtl/core/checked_int64_alu.sv
tb/tb_checked_int64_alu.sv
